>>> rtl/rrbc_pkg.sv
// rrbc_pkg: shared types and constants of the rr interval beat classifier
// used by rrbc_classify and rr_interval_beat_classifier; no dependencies
package rrbc_pkg;

	localparam int QRS_WIDTH   = 31;
	localparam int LIMIT_WIDTH = 16;
	localparam int CFG_IDX_W   = 2;

	typedef enum logic [1:0] {
		CLASS_NORMAL      = 2'd0,
		CLASS_VENTRICULAR = 2'd1,
		CLASS_ATRIAL      = 2'd2,
		CLASS_NO_HISTORY  = 2'd3
	} beat_class_t;

	localparam logic [CFG_IDX_W-1:0] CFG_SIMILAR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VERY_SHORT = 2'd2;

	localparam logic [LIMIT_WIDTH-1:0] SIMILAR_RESET    = 16'd40;
	localparam logic [LIMIT_WIDTH-1:0] SHORT_RESET      = 16'd150;
	localparam logic [LIMIT_WIDTH-1:0] VERY_SHORT_RESET = 16'd120;

	typedef struct packed {
		logic [LIMIT_WIDTH-1:0] similar;
		logic [LIMIT_WIDTH-1:0] short_lim;
		logic [LIMIT_WIDTH-1:0] very_short;
	} cfg_limits_t;

endpackage

>>> rtl/rrbc_classify.sv
// rrbc_classify: combinational beat rules on three signed rr intervals
// depends on rrbc_pkg for the class codes and the limit struct
module rrbc_classify
	import rrbc_pkg::*;
#(
	parameter int POSITION_BITS = 31
) (
	input  logic signed [POSITION_BITS:0] rr1,
	input  logic signed [POSITION_BITS:0] rr2,
	input  logic signed [POSITION_BITS:0] rr3,
	input  logic                          no_history,
	input  cfg_limits_t                   limits,
	output beat_class_t                   beat_class
);

	// wide enough for 100 times a sum of two intervals
	localparam int CW = POSITION_BITS + 9;

	localparam logic signed [CW-1:0] K2   = CW'(2);
	localparam logic signed [CW-1:0] K6   = CW'(6);
	localparam logic signed [CW-1:0] K10  = CW'(10);
	localparam logic signed [CW-1:0] K18  = CW'(18);
	localparam logic signed [CW-1:0] K88  = CW'(88);
	localparam logic signed [CW-1:0] K95  = CW'(95);
	localparam logic signed [CW-1:0] K100 = CW'(100);

	logic signed [CW-1:0] r1, r2, r3;
	logic signed [CW-1:0] sim, sh, vs;
	logic signed [CW-1:0] d21, d23, ad21, ad23;
	logic                 premature, pause, rule_a, rule_b, rule_c;

	always_comb begin
		r1  = CW'(rr1);
		r2  = CW'(rr2);
		r3  = CW'(rr3);
		sim = $signed(CW'(limits.similar));
		sh  = $signed(CW'(limits.short_lim));
		vs  = $signed(CW'(limits.very_short));

		d21  = r2 - r1;
		d23  = r2 - r3;
		ad21 = d21[CW-1] ? -d21 : d21;
		ad23 = d23[CW-1] ? -d23 : d23;

		premature = (r2 * K100 <= r1 * K88) && (r3 * K95 >= r1 * K100);
		pause     = (r2 + r3) >= (r1 * K2);
		rule_a    = (ad21 < sim) && (r1 < sh) && (r2 < sh) && (r3 * K10 > (r1 + r2) * K6);
		rule_b    = (ad23 < sim) && (r3 < sh) && (r2 < sh) && (r1 * K10 > (r3 + r2) * K6);
		rule_c    = (r2 < vs) && ((r2 * K18 < r1 * K10) || (r2 * K18 < r3 * K10));

		if (no_history) begin
			beat_class = CLASS_NO_HISTORY;
		end else if (rule_a || rule_b || rule_c) begin
			beat_class = CLASS_VENTRICULAR;
		end else if (premature) begin
			beat_class = pause ? CLASS_VENTRICULAR : CLASS_ATRIAL;
		end else begin
			beat_class = CLASS_NORMAL;
		end
	end

endmodule

>>> rtl/rr_interval_beat_classifier.sv
// rr_interval_beat_classifier: top level, position history, pipeline and config registers
// depends on rrbc_pkg and rrbc_classify
//
//   channel  signals                                   direction
//   in       in_valid, in_stall, qrs_position, restart  beat in
//   out      out_valid, out_stall, beat_class           beat out
//   cfg      cfg_we, cfg_index, cfg_data                register write
//
// one beat per cycle sustained while out_stall stays low; the class leaves the class register
// stages: window register, interval register, class register
// reset clears the position history, the stage valids and the limits to their defaults
// out_stall holds the class register; the stages behind it keep filling, then in_stall rises
module rr_interval_beat_classifier
	import rrbc_pkg::*;
#(
	parameter int POSITION_BITS = 31
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [QRS_WIDTH-1:0]   qrs_position,
	input  logic                   restart,
	output logic                   out_valid,
	input  logic                   out_stall,
	output beat_class_t            beat_class,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [LIMIT_WIDTH-1:0] cfg_data
);

	typedef logic [POSITION_BITS-1:0]        pos_t;
	typedef logic signed [POSITION_BITS:0]   rr_t;

	cfg_limits_t limits_q;
	pos_t        hist_q [3];
	pos_t        win_s1 [4];
	logic        v_s1, v_s2, out_valid_q;
	rr_t         rr1_s2, rr2_s2, rr3_s2;
	logic        nohist_s2;
	beat_class_t class_q, class_d;
	logic        rdy_out, en_s2, en_s1, in_acc;
	pos_t        pos, p1, p2, p3;

	assign rdy_out  = !out_valid_q || !out_stall;
	assign en_s2    = !v_s2 || rdy_out;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign in_acc   = in_valid && en_s1;

	assign out_valid  = out_valid_q;
	assign beat_class = class_q;

	always_comb begin
		pos = POSITION_BITS'(qrs_position);
		p1  = restart ? '0 : hist_q[0];
		p2  = restart ? '0 : hist_q[1];
		p3  = restart ? '0 : hist_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.similar    <= SIMILAR_RESET;
			limits_q.short_lim  <= SHORT_RESET;
			limits_q.very_short <= VERY_SHORT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SIMILAR:    limits_q.similar    <= cfg_data;
				CFG_SHORT:      limits_q.short_lim  <= cfg_data;
				CFG_VERY_SHORT: limits_q.very_short <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// history shifts on every taken beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0] <= '0;
			hist_q[1] <= '0;
			hist_q[2] <= '0;
		end else if (in_acc) begin
			hist_q[0] <= p2;
			hist_q[1] <= p3;
			hist_q[2] <= pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_out) begin
				out_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			win_s1[0] <= p1;
			win_s1[1] <= p2;
			win_s1[2] <= p3;
			win_s1[3] <= pos;
		end
		if (en_s2 && v_s1) begin
			rr1_s2    <= $signed({1'b0, win_s1[1]}) - $signed({1'b0, win_s1[0]});
			rr2_s2    <= $signed({1'b0, win_s1[2]}) - $signed({1'b0, win_s1[1]});
			rr3_s2    <= $signed({1'b0, win_s1[3]}) - $signed({1'b0, win_s1[2]});
			nohist_s2 <= (win_s1[0] == '0) || (win_s1[1] == '0) ||
				(win_s1[2] == '0) || (win_s1[3] == '0);
		end
		if (rdy_out && v_s2) begin
			class_q <= class_d;
		end
	end

	rrbc_classify #(
		.POSITION_BITS(POSITION_BITS)
	) u_classify (
		.rr1        (rr1_s2),
		.rr2        (rr2_s2),
		.rr3        (rr3_s2),
		.no_history (nohist_s2),
		.limits     (limits_q),
		.beat_class (class_d)
	);

	a_empty_out_takes_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> !in_stall)
		else $error("input stalled with empty result register");

	a_restart_window: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && restart |=> (win_s1[0] == '0) && (win_s1[1] == '0) && (win_s1[2] == '0))
		else $error("restart did not clear window");

	a_s2_drains: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_valid_q |=> out_valid_q)
		else $error("interval stage did not move to empty result register");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> hist_q[2] == $past(pos))
		else $error("history did not take new position");

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for rr_interval_beat_classifier, directed table then random rhythms
// depends on rrbc_pkg and the rtl top level; predicts each beat class and checks in order
`timescale 1ns / 100ps

module testbench;
	import rrbc_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE_CYCLES = 6;
	localparam int NUM_DIRECTED = 23;
	localparam int NUM_PHASES = 5;
	localparam int BEATS_PER_PHASE = 110;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic KNOWN = 1'b1;
	localparam logic PREDICT = 1'b0;

	typedef struct packed {
		logic [QRS_WIDTH-1:0] pos;
		logic                 clear;
		logic                 known;
		beat_class_t          want;
	} beat_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [QRS_WIDTH-1:0]   qrs_position;
	logic                   restart;
	logic                   out_valid;
	logic                   out_stall;
	beat_class_t            beat_class;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [LIMIT_WIDTH-1:0] cfg_data;

	logic [QRS_WIDTH-1:0]   history [3];
	logic [LIMIT_WIDTH-1:0] lim_similar;
	logic [LIMIT_WIDTH-1:0] lim_short;
	logic [LIMIT_WIDTH-1:0] lim_very_short;
	beat_class_t            pending_classes [$];
	int                     mismatch_count = 0;
	int                     cycle_count = 0;
	int                     idle_pct = 15;
	bit                     no_idle = 0;
	logic [QRS_WIDTH-1:0]   rhythm_last = 31'd1000;
	int                     rhythm_base = 200;

	beat_row_t directed_rows [NUM_DIRECTED] = '{
		'{31'd1000, 1'b1, KNOWN, CLASS_NO_HISTORY},
		'{31'd1200, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'd1400, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'd1570, 1'b0, PREDICT, CLASS_NORMAL},
		'{31'd1790, 1'b0, PREDICT, CLASS_NORMAL},
		'{31'd5000, 1'b1, KNOWN, CLASS_NO_HISTORY},
		'{31'd5200, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'd5350, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'd5610, 1'b0, PREDICT, CLASS_NORMAL},
		'{31'd9000, 1'b1, KNOWN, CLASS_NO_HISTORY},
		'{31'd9200, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'd9300, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'd9500, 1'b0, PREDICT, CLASS_NORMAL},
		'{31'd20000, 1'b1, KNOWN, CLASS_NO_HISTORY},
		'{31'd20100, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'd20210, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'd20410, 1'b0, PREDICT, CLASS_NORMAL},
		'{31'd0, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'h7FFFFFFF, 1'b1, KNOWN, CLASS_NO_HISTORY},
		'{31'h7FFFFC00, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'h7FFFFB00, 1'b0, KNOWN, CLASS_NO_HISTORY},
		'{31'h7FFFFA80, 1'b0, PREDICT, CLASS_NORMAL},
		'{31'd1, 1'b0, PREDICT, CLASS_NORMAL}
	};

	rr_interval_beat_classifier u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.qrs_position (qrs_position),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.beat_class   (beat_class),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic beat_class_t classify_beat(input logic [QRS_WIDTH-1:0] pos,
			input logic clear);
		longint q1, q2, q3, q4, rr1, rr2, rr3, sim, sh, vsh;
		logic rule_a, rule_b, rule_c, premature, pause;
		if (clear) begin
			history = '{default: '0};
		end
		q1 = history[0];
		q2 = history[1];
		q3 = history[2];
		q4 = pos;
		history[0] = history[1];
		history[1] = history[2];
		history[2] = pos;
		if (q1 == 0 || q2 == 0 || q3 == 0 || q4 == 0)
			return CLASS_NO_HISTORY;
		rr1 = q2 - q1;
		rr2 = q3 - q2;
		rr3 = q4 - q3;
		sim = lim_similar;
		sh = lim_short;
		vsh = lim_very_short;
		rule_a = ((rr2 > rr1) ? rr2 - rr1 : rr1 - rr2) < sim && rr1 < sh && rr2 < sh &&
			10 * rr3 > 6 * (rr1 + rr2);
		rule_b = ((rr2 > rr3) ? rr2 - rr3 : rr3 - rr2) < sim && rr3 < sh && rr2 < sh &&
			10 * rr1 > 6 * (rr3 + rr2);
		rule_c = rr2 < vsh && (18 * rr2 < 10 * rr1 || 18 * rr2 < 10 * rr3);
		premature = (100 * rr2 <= 88 * rr1) && (95 * rr3 >= 100 * rr1);
		pause = (rr2 + rr3) >= 2 * rr1;
		if (rule_a || rule_b || rule_c)
			return CLASS_VENTRICULAR;
		if (premature)
			return pause ? CLASS_VENTRICULAR : CLASS_ATRIAL;
		return CLASS_NORMAL;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic send_beat(input logic [QRS_WIDTH-1:0] pos, input logic clear,
			input logic known, input beat_class_t want_known);
		int gap;
		beat_class_t want;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			gap = int'($urandom_range(1, 12));
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		qrs_position <= pos;
		restart <= clear;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		want = classify_beat(pos, clear);
		pending_classes.push_back(known ? want_known : want);
	endtask

	task automatic pick_beat(output logic [QRS_WIDTH-1:0] pos, output logic clear);
		int roll;
		int rr;
		roll = int'($urandom_range(0, 99));
		clear = 1'b0;
		if (roll < 4) begin
			clear = 1'b1;
			rhythm_base = int'($urandom_range(40, 400));
			pos = ($urandom_range(0, 3) == 0) ? QRS_WIDTH'($urandom) :
				QRS_WIDTH'($urandom_range(1, 100000));
		end else if (roll < 7) begin
			pos = '0;
		end else if (roll < 10) begin
			pos = QRS_WIDTH'($urandom);
		end else if (roll < 15) begin
			pos = QRS_WIDTH'(rhythm_last - $urandom_range(0, 300));
		end else begin
			roll = int'($urandom_range(0, 99));
			if (roll < 55)
				rr = rhythm_base + int'($urandom_range(0, 40)) - 20;
			else if (roll < 80)
				rr = rhythm_base * int'($urandom_range(40, 95)) / 100;
			else
				rr = rhythm_base * int'($urandom_range(100, 200)) / 100;
			pos = QRS_WIDTH'(rhythm_last + rr);
		end
		if (pos != 0)
			rhythm_last = pos;
	endtask

	task automatic wait_drained();
		while (pending_classes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_limits(input logic [LIMIT_WIDTH-1:0] sim, input logic [LIMIT_WIDTH-1:0] sh,
			input logic [LIMIT_WIDTH-1:0] vsh, input bit poke_unused);
		logic [CFG_IDX_W-1:0]   idx [4];
		logic [LIMIT_WIDTH-1:0] val [4];
		int n;
		idx = '{CFG_SIMILAR, CFG_SHORT, CFG_VERY_SHORT, CFG_UNUSED};
		val = '{sim, sh, vsh, LIMIT_WIDTH'($urandom)};
		n = poke_unused ? 4 : 3;
		in_valid <= 1'b0;
		wait_drained();
		for (int i = 0; i < n; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			case (idx[i])
				CFG_SIMILAR: lim_similar = val[i];
				CFG_SHORT: lim_short = val[i];
				CFG_VERY_SHORT: lim_very_short = val[i];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	initial begin : back_pressure
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (no_idle)
				stall_left = 0;
			else if (stall_left > 0)
				stall_left--;
			else if ($urandom_range(0, 99) < idle_pct / 3)
				stall_left = int'($urandom_range(1, 12));
			out_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin : check_beats
		beat_class_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_classes.size() == 0) begin
				flag_mismatch($sformatf("beat class %0d with no beat pending", beat_class));
			end else begin
				want = pending_classes.pop_front();
				if (beat_class !== want)
					flag_mismatch($sformatf("beat class %0d, predicted %0d", beat_class, want));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [QRS_WIDTH-1:0] pos;
		logic clear;
		in_valid <= 1'b0;
		qrs_position <= '0;
		restart <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_SIMILAR;
		cfg_data <= '0;
		arst_n <= 1'b0;
		history = '{default: '0};
		lim_similar = SIMILAR_RESET;
		lim_short = SHORT_RESET;
		lim_very_short = VERY_SHORT_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIRECTED; i++)
			send_beat(directed_rows[i].pos, directed_rows[i].clear, directed_rows[i].known,
				directed_rows[i].want);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase)
				0: load_limits(LIMIT_WIDTH'($urandom_range(1, 100)),
					LIMIT_WIDTH'($urandom_range(100, 300)),
					LIMIT_WIDTH'($urandom_range(50, 200)), 1'b0);
				1: load_limits('0, '0, '0, 1'b1);
				2: load_limits('1, '1, '1, 1'b0);
				3: load_limits(LIMIT_WIDTH'($urandom_range(0, 80)),
					LIMIT_WIDTH'($urandom_range(0, 400)),
					LIMIT_WIDTH'($urandom_range(0, 400)), 1'b1);
				default: begin
					load_limits(SIMILAR_RESET, SHORT_RESET, VERY_SHORT_RESET, 1'b0);
					no_idle = 1'b1;
					idle_pct = 0;
				end
			endcase
			for (int k = 0; k < BEATS_PER_PHASE; k++) begin
				if (k % 40 == 0 && !no_idle)
					idle_pct = int'($urandom_range(0, 2)) * 15;
				pick_beat(pos, clear);
				send_beat(pos, clear, PREDICT, CLASS_NORMAL);
			end
		end

		in_valid <= 1'b0;
		wait_drained();
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
